FILE: rtl/dsed_pkg.sv
// ----------------------------------------------------------------------------
// dsed_pkg
// Shared types and constants of the DoG scale-space extremum detector.
// ----------------------------------------------------------------------------
package dsed_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int LAYERS     = 3;
   localparam int WIN_CELLS  = 27;
   localparam int LAYER_CELLS = 9;
   localparam int CENTRE_CELL = 13;
   localparam int COORD_W    = 12;
   localparam int THR_W      = 15;
   localparam int DIM_W      = 13;
   localparam int BORDER_W   = 7;
   localparam int CSR_DATA_W = 16;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_DIM    = 3;

   localparam int OUT_DEPTH  = 4;
   localparam int OUT_PTR_W  = 2;
   localparam int OUT_CNT_W  = 3;

   localparam logic [THR_W-1:0]    THRESHOLD_RESET = THR_W'(0);
   localparam logic [DIM_W-1:0]    WIDTH_RESET     = DIM_W'(640);
   localparam logic [DIM_W-1:0]    HEIGHT_RESET    = DIM_W'(480);
   localparam logic [BORDER_W-1:0] BORDER_RESET    = BORDER_W'(5);

   typedef enum logic [1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_WIDTH     = 2'd1,
      CSR_HEIGHT    = 2'd2,
      CSR_BORDER    = 2'd3
   } csr_index_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef sample_type window_type [WIN_CELLS];
   typedef sample_type layer_samples_type [LAYERS];

   typedef struct packed {
      sample_type lower_sample;
      sample_type centre_sample;
      sample_type upper_sample;
      logic       frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [COORD_W-1:0] peak_row;
      logic [COORD_W-1:0] peak_col;
      sample_type         peak_value;
      logic               is_maximum;
   } rsp_payload_type;

   typedef struct packed {
      csr_index_type         index;
      logic [CSR_DATA_W-1:0] data;
   } csr_payload_type;

   // Position of the window centre travelling alongside the window
   typedef struct packed {
      logic               valid;
      logic               in_border;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } cand_meta_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type data;
   } push_type;

endpackage

FILE: rtl/dsed_chan_if.sv
// ----------------------------------------------------------------------------
// dsed_chan_if
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface dsed_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/dsed_ram.sv
// ----------------------------------------------------------------------------
// dsed_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module dsed_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/dsed_line_window.sv
// ----------------------------------------------------------------------------
// dsed_line_window
// Raster counters, line-store read-modify-write and the 3x3x3 window.
// ----------------------------------------------------------------------------
module dsed_line_window
   import dsed_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  req_payload_type                      beat,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]       width_eff,
   input  logic [DIM_W-1:0]                     height_eff,
   input  logic [BORDER_W-1:0]                  border_eff,
   output window_type                           window,
   output cand_meta_type                        meta,
   output logic                                 s1_busy
);

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int CB_W   = ((CW > BORDER_W) ? CW : BORDER_W) + 1;
   localparam int PC_W   = (CB_W > COORD_W) ? CB_W : COORD_W;
   localparam int LINE_W = 2 * LAYERS * SAMPLE_W;

   // raster position of the next beat
   logic [COORD_W-1:0] row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [COORD_W-1:0] row_cur;
   logic [CW-1:0]      col_cur;
   logic               col_wrap, row_wrap;

   // stage 1: line-store data returns
   logic               s1_valid_ff;
   logic [COORD_W-1:0] s1_row_ff;
   logic [CW-1:0]      s1_col_ff;
   layer_samples_type  s1_fresh_ff;
   logic               s1_fwd_ff;
   logic [LINE_W-1:0]  s1_fwd_word_ff;
   logic [LINE_W-1:0]  ram_rd_data;
   logic [LINE_W-1:0]  line_word;
   logic [LINE_W-1:0]  line_word_new;
   layer_samples_type  above1, above2;

   window_type         window_ff, window_in;
   cand_meta_type      meta_ff, meta_in;
   logic               in_rows, in_cols;
   logic [PC_W-1:0]    col_m1;

   always_comb begin
      row_cur  = beat.frame_start ? '0 : row_ff;
      col_cur  = beat.frame_start ? '0 : col_ff;
      col_wrap = (CB_W'(col_cur) + CB_W'(1)) >= CB_W'(width_eff);
      row_wrap = (DIM_W'(row_cur) + DIM_W'(1)) >= height_eff;
      row_in   = row_ff;
      col_in   = col_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : COORD_W'(row_cur + COORD_W'(1));
         end else begin
            col_in = CW'(col_cur + CW'(1));
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   dsed_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (line_word_new),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (ram_rd_data)
   );

   // Stage 1 registers; forward the word being written when the same column is read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_row_ff      <= row_cur;
         s1_col_ff      <= col_cur;
         s1_fresh_ff[0] <= beat.lower_sample;
         s1_fresh_ff[1] <= beat.centre_sample;
         s1_fresh_ff[2] <= beat.upper_sample;
         s1_fwd_ff      <= s1_valid_ff && (s1_col_ff == col_cur);
         s1_fwd_word_ff <= line_word_new;
      end
   end

   // Per layer: slot 0 holds row r-1, slot 1 row r-2
   always_comb begin
      line_word     = s1_fwd_ff ? s1_fwd_word_ff : ram_rd_data;
      line_word_new = '0;
      for (int l = 0; l < LAYERS; l++) begin
         above1[l] = line_word[(2*l)*SAMPLE_W +: SAMPLE_W];
         above2[l] = line_word[(2*l+1)*SAMPLE_W +: SAMPLE_W];
         line_word_new[(2*l)*SAMPLE_W +: SAMPLE_W]   = s1_fresh_ff[l];
         line_word_new[(2*l+1)*SAMPLE_W +: SAMPLE_W] = above1[l];
      end
   end

   always_comb begin
      window_in = window_ff;
      if (s1_valid_ff) begin
         for (int l = 0; l < LAYERS; l++) begin
            for (int k = 0; k < 3; k++) begin
               window_in[l*LAYER_CELLS + k*3]     = window_ff[l*LAYER_CELLS + k*3 + 1];
               window_in[l*LAYER_CELLS + k*3 + 1] = window_ff[l*LAYER_CELLS + k*3 + 2];
            end
            window_in[l*LAYER_CELLS + 2] = above2[l];
            window_in[l*LAYER_CELLS + 5] = above1[l];
            window_in[l*LAYER_CELLS + 8] = s1_fresh_ff[l];
         end
      end
   end

   // Centre sits at (row-1, col-1) of the stage-1 beat
   always_comb begin
      in_rows = (DIM_W'(s1_row_ff) > DIM_W'(border_eff)) &&
                ((DIM_W'(s1_row_ff) + DIM_W'(border_eff)) <= height_eff);
      in_cols = (CB_W'(s1_col_ff) > CB_W'(border_eff)) &&
                ((CB_W'(s1_col_ff) + CB_W'(border_eff)) <= CB_W'(width_eff));
      col_m1  = PC_W'(s1_col_ff) - PC_W'(1);
      meta_in.valid     = s1_valid_ff;
      meta_in.in_border = in_rows && in_cols;
      meta_in.row       = COORD_W'(s1_row_ff - COORD_W'(1));
      meta_in.col       = col_m1[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= '{default: '0};
         meta_ff.valid <= 1'b0;
      end else begin
         window_ff     <= window_in;
         meta_ff.valid <= meta_in.valid;
      end
      meta_ff.in_border <= meta_in.in_border;
      meta_ff.row       <= meta_in.row;
      meta_ff.col       <= meta_in.col;
   end

   assign window  = window_ff;
   assign meta    = meta_ff;
   assign s1_busy = s1_valid_ff;

endmodule

FILE: rtl/dsed_extremum_test.sv
// ----------------------------------------------------------------------------
// dsed_extremum_test
// Contrast and 26-neighbour comparison on the window centre.
// ----------------------------------------------------------------------------
module dsed_extremum_test
   import dsed_pkg::*;
(
   input  window_type         window,
   input  cand_meta_type      meta,
   input  logic [THR_W-1:0]   threshold,
   output push_type           push
);

   sample_type          centre;
   logic [SAMPLE_W:0]   magnitude;
   logic                contrast_ok;
   logic                all_le, all_ge;
   logic                is_max, is_min;

   always_comb begin
      centre    = window[CENTRE_CELL];
      magnitude = centre[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {centre[SAMPLE_W-1], centre})
                                     : {1'b0, centre};
      contrast_ok = magnitude > (SAMPLE_W+1)'(threshold);
      all_le = 1'b1;
      all_ge = 1'b1;
      for (int k = 0; k < WIN_CELLS; k++) begin
         if (window[k] > centre) all_le = 1'b0;
         if (window[k] < centre) all_ge = 1'b0;
      end
      // ties with a neighbour still count
      is_max = !centre[SAMPLE_W-1] && (centre != '0) && all_le;
      is_min = centre[SAMPLE_W-1] && all_ge;

      push.valid           = meta.valid && meta.in_border && contrast_ok &&
                             (is_max || is_min);
      push.data.peak_row   = meta.row;
      push.data.peak_col   = meta.col;
      push.data.peak_value = centre;
      push.data.is_maximum = is_max;
   end

endmodule

FILE: rtl/dsed_result_fifo.sv
// ----------------------------------------------------------------------------
// dsed_result_fifo
// Small output queue decoupling the pipeline from result backpressure.
// ----------------------------------------------------------------------------
module dsed_result_fifo
   import dsed_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  push_type              push,
   dsed_chan_if.source           rsp_chan,
   output logic [OUT_CNT_W-1:0]  count
);

   rsp_payload_type        entry_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [OUT_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;

   assign pop = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      count_in = count_ff;
      priority if (push.valid && !pop) begin
         count_in = OUT_CNT_W'(count_ff + OUT_CNT_W'(1));
      end else if (!push.valid && pop) begin
         count_in = OUT_CNT_W'(count_ff - OUT_CNT_W'(1));
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) wr_ptr_ff <= OUT_PTR_W'(wr_ptr_ff + OUT_PTR_W'(1));
         if (pop)        rd_ptr_ff <= OUT_PTR_W'(rd_ptr_ff + OUT_PTR_W'(1));
         count_ff <= count_in;
      end
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.data;
      end
   end

   assign rsp_chan.valid   = (count_ff != '0);
   assign rsp_chan.payload = entry_ff[rd_ptr_ff];
   assign count            = count_ff;

endmodule

FILE: rtl/dog_scale_space_extremum_detector_core.sv
// ----------------------------------------------------------------------------
// dog_scale_space_extremum_detector_core
// 26-neighbour extremum detection over three DoG layers in raster order.
// ----------------------------------------------------------------------------
// Throughput: one req beat per cycle while req_ready is high; the line-store
//   RAM is read and written once per beat (read at accept, written back in the
//   following cycle, forwarded). Candidates pass the stage-1, window/meta and
//   result-queue registers before rsp. req_ready drops only when the 4-entry
//   result queue plus the two pipeline stages could overflow under rsp
//   backpressure. Reset: counters, window, valid flags and configuration
//   registers return to defaults; line stores are not cleared.
// ----------------------------------------------------------------------------
module dog_scale_space_extremum_detector_core
   import dsed_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  logic         clock,
   input  logic         reset,
   dsed_chan_if.sink    req_chan,
   dsed_chan_if.source  rsp_chan,
   dsed_chan_if.sink    csr_chan
);

   localparam int WW = $clog2(MAX_WIDTH+1);

   logic [THR_W-1:0]      cfg_threshold_ff;
   logic [WW-1:0]         cfg_width_ff;
   logic [DIM_W-1:0]      cfg_height_ff;
   logic [BORDER_W-1:0]   cfg_border_ff;
   logic [DIM_W-1:0]      raw_dim;
   logic [BORDER_W-1:0]   raw_border;
   logic                  csr_write;

   logic                  req_accept;
   window_type            window;
   cand_meta_type         meta;
   logic                  s1_busy;
   push_type              push;
   logic [OUT_CNT_W-1:0]  fifo_count;
   logic [OUT_CNT_W-1:0]  occupancy;

   // Configuration: clamp on write so the datapath sees effective values
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;
   assign raw_dim        = csr_chan.payload.data[DIM_W-1:0];
   assign raw_border     = csr_chan.payload.data[BORDER_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_threshold_ff <= THRESHOLD_RESET;
         cfg_width_ff     <= WW'(WIDTH_RESET);
         cfg_height_ff    <= HEIGHT_RESET;
         cfg_border_ff    <= BORDER_RESET;
      end else if (csr_write) begin
         unique case (csr_chan.payload.index)
            CSR_THRESHOLD: begin
               cfg_threshold_ff <= csr_chan.payload.data[THR_W-1:0];
            end
            CSR_WIDTH: begin
               if (raw_dim < DIM_W'(MIN_DIM)) begin
                  cfg_width_ff <= WW'(MIN_DIM);
               end else if ({1'b0, raw_dim} > (DIM_W+1)'(MAX_WIDTH)) begin
                  cfg_width_ff <= WW'(MAX_WIDTH);
               end else begin
                  cfg_width_ff <= WW'(raw_dim);
               end
            end
            CSR_HEIGHT: begin
               if (raw_dim < DIM_W'(MIN_DIM)) begin
                  cfg_height_ff <= DIM_W'(MIN_DIM);
               end else if (raw_dim > DIM_W'(MAX_HEIGHT)) begin
                  cfg_height_ff <= DIM_W'(MAX_HEIGHT);
               end else begin
                  cfg_height_ff <= raw_dim;
               end
            end
            CSR_BORDER: begin
               cfg_border_ff <= (raw_border == '0) ? BORDER_W'(1) : raw_border;
            end
         endcase
      end
   end

   // Hold off input while in-flight beats could overrun the result queue
   assign occupancy      = OUT_CNT_W'(fifo_count + OUT_CNT_W'(s1_busy) + OUT_CNT_W'(meta.valid));
   assign req_chan.ready = occupancy < OUT_CNT_W'(OUT_DEPTH);
   assign req_accept     = req_chan.valid && req_chan.ready;

   dsed_line_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_window (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .beat       (req_chan.payload),
      .width_eff  (cfg_width_ff),
      .height_eff (cfg_height_ff),
      .border_eff (cfg_border_ff),
      .window     (window),
      .meta       (meta),
      .s1_busy    (s1_busy)
   );

   dsed_extremum_test u_extremum_test (
      .window    (window),
      .meta      (meta),
      .threshold (cfg_threshold_ff),
      .push      (push)
   );

   dsed_result_fifo u_result_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .rsp_chan (rsp_chan),
      .count    (fifo_count)
   );

   a_no_queue_overrun: assert property (@(posedge clock) disable iff (reset)
      occupancy <= OUT_CNT_W'(OUT_DEPTH))
      else $error("result queue plus pipeline exceed queue depth");

   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_busy ##1 meta.valid)
      else $error("accepted beat did not advance through the pipeline");

   a_peak_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.payload.peak_value != '0))
      else $error("zero-valued candidate emitted");

   a_flag_matches_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         (rsp_chan.payload.is_maximum == !rsp_chan.payload.peak_value[SAMPLE_W-1]))
      else $error("max/min flag disagrees with candidate sign");

endmodule

FILE: bench/dsed_peak_checker.sv
// ----------------------------------------------------------------------------
// dsed_peak_checker
// Watches the req, rsp and csr channels of the extremum detector, predicts
// every candidate from its own copy of the line stores, window and counters,
// and compares each rsp beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module dsed_peak_checker
   import dsed_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  csr_payload_type csr_payload,
   output int              mismatch_count,
   output int              pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_COLS = 4096;

   logic [THR_W-1:0]    threshold;
   logic [DIM_W-1:0]    width_cfg;
   logic [DIM_W-1:0]    height_cfg;
   logic [BORDER_W-1:0] border_cfg;

   // [layer][column][0] = row above, [1] = two rows above
   int              line_mem [LAYERS][MAX_COLS][2];
   int              cells [WIN_CELLS];
   int unsigned     row_pos;
   int unsigned     col_pos;
   rsp_payload_type pending_peaks [$];

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      return (v < MIN_DIM) ? MIN_DIM : ((v > hi) ? hi : v);
   endfunction

   function automatic void shift_in(int layer, int unsigned c, int fresh);
      int base;
      int above1;
      int above2;
      int k;
      base   = layer * LAYER_CELLS;
      above1 = line_mem[layer][c][0];
      above2 = line_mem[layer][c][1];
      for (k = 0; k < 3; k++) begin
         cells[base + k*3]     = cells[base + k*3 + 1];
         cells[base + k*3 + 1] = cells[base + k*3 + 2];
      end
      cells[base + 2] = above2;
      cells[base + 5] = above1;
      cells[base + 8] = fresh;
      line_mem[layer][c][1] = above1;
      line_mem[layer][c][0] = fresh;
   endfunction

   // Take in one position; return 1 with the candidate when the centre is a peak
   function automatic bit detect_peak(input req_payload_type beat,
                                      output rsp_payload_type peak);
      int unsigned w;
      int unsigned h;
      int unsigned b;
      int unsigned r;
      int unsigned c;
      int          val;
      int          mag;
      int          k;
      bit          in_border;
      bit          is_max;
      bit          is_min;
      bit          found;
      w     = clamp_dim(width_cfg, MAX_COLS);
      h     = clamp_dim(height_cfg, MAX_HEIGHT);
      b     = (border_cfg == '0) ? 1 : border_cfg;
      peak  = '0;
      found = 1'b0;
      if (beat.frame_start) begin
         row_pos = 0;
         col_pos = 0;
      end
      r = row_pos;
      c = col_pos % MAX_COLS;
      shift_in(0, c, beat.lower_sample);
      shift_in(1, c, beat.centre_sample);
      shift_in(2, c, beat.upper_sample);

      // centre trails the input by one row and one column
      in_border = r >= 1 && c >= 1 && (r - 1) >= b && (r - 1) + b < h &&
                  (c - 1) >= b && (c - 1) + b < w;
      if (in_border) begin
         val = cells[CENTRE_CELL];
         mag = (val < 0) ? -val : val;
         if (mag > int'(threshold)) begin
            is_max = val > 0;
            is_min = val < 0;
            for (k = 0; k < WIN_CELLS; k++) begin
               if (cells[k] > val) is_max = 1'b0;
               if (cells[k] < val) is_min = 1'b0;
            end
            if (is_max || is_min) begin
               peak.peak_row   = COORD_W'(r - 1);
               peak.peak_col   = COORD_W'(c - 1);
               peak.peak_value = sample_type'(val);
               peak.is_maximum = is_max;
               found = 1'b1;
            end
         end
      end

      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return found;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_payload_type peak;
      rsp_payload_type want;
      int              k;
      if (reset) begin
         threshold  = THRESHOLD_RESET;
         width_cfg  = WIDTH_RESET;
         height_cfg = HEIGHT_RESET;
         border_cfg = BORDER_RESET;
         for (k = 0; k < WIN_CELLS; k++) cells[k] = 0;
         row_pos = 0;
         col_pos = 0;
      end else begin
         // check the outgoing beat before this edge's input can add to the queue
         if (rsp_valid && rsp_ready) begin
            if (pending_peaks.size() == 0) begin
               $error("unexpected peak at row %0d col %0d value %0d",
                      rsp_payload.peak_row, rsp_payload.peak_col,
                      rsp_payload.peak_value);
               mismatch_count++;
            end else begin
               want = pending_peaks.pop_front();
               if (rsp_payload.peak_row !== want.peak_row) begin
                  $error("peak_row: expected %0d, got %0d",
                         want.peak_row, rsp_payload.peak_row);
                  mismatch_count++;
               end
               if (rsp_payload.peak_col !== want.peak_col) begin
                  $error("peak_col: expected %0d, got %0d",
                         want.peak_col, rsp_payload.peak_col);
                  mismatch_count++;
               end
               if (rsp_payload.peak_value !== want.peak_value) begin
                  $error("peak_value: expected %0d, got %0d",
                         want.peak_value, rsp_payload.peak_value);
                  mismatch_count++;
               end
               if (rsp_payload.is_maximum !== want.is_maximum) begin
                  $error("is_maximum: expected %0d, got %0d",
                         want.is_maximum, rsp_payload.is_maximum);
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_payload.index)
               CSR_THRESHOLD: threshold  = csr_payload.data[THR_W-1:0];
               CSR_WIDTH:     width_cfg  = csr_payload.data[DIM_W-1:0];
               CSR_HEIGHT:    height_cfg = csr_payload.data[DIM_W-1:0];
               CSR_BORDER:    border_cfg = csr_payload.data[BORDER_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (detect_peak(req_payload, peak)) pending_peaks = {pending_peaks, peak};
         end
      end
      pending_count = pending_peaks.size();
   end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the DoG extremum detector: a directed 5x5 frame with extreme
// samples and ties, then randomized frames over a series of register settings
// (tiny, clamped, oversized border, width shrunk inside a frame, oversized
// width and height), with varying idle patterns on both channels and a long
// rsp stall. Checking is done by dsed_peak_checker.
// ----------------------------------------------------------------------------
module testbench
   import dsed_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         STALL_LIMIT     = 4000;
   localparam int         DRAIN_CYCLES    = 8;
   localparam int         RSP_HOLD_CYCLES = 300;
   localparam int         WIDE_BEATS      = 100;
   localparam sample_type SAMPLE_MAX      = 16'sh7FFF;
   localparam sample_type SAMPLE_MIN      = 16'sh8000;

   logic clock;
   logic reset;

   dsed_chan_if #(.payload_type(req_payload_type)) req_chan ();
   dsed_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();
   dsed_chan_if #(.payload_type(csr_payload_type)) csr_chan ();

   int req_gap_pct;
   int rsp_stall_pct;
   int hold_requests;
   int holds_done = 0;
   int quiet_cycles = 0;
   int mismatch_count;
   int pending_count;

   dog_scale_space_extremum_detector_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   dsed_peak_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_payload    (req_chan.payload),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_payload    (rsp_chan.payload),
      .csr_valid      (csr_chan.valid),
      .csr_ready      (csr_chan.ready),
      .csr_payload    (csr_chan.payload),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: random stalls, or a long hold when one is requested
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES - 1) @(negedge clock);
            holds_done++;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $error("no beat on any channel for %0d cycles", STALL_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic sample_type random_sample();
      int pick;
      int mag;
      pick = $urandom_range(99);
      mag  = $urandom_range(32767, 1000);
      if (pick < 65) return sample_type'(int'($urandom_range(40)) - 20);
      if (pick < 85) return sample_type'($urandom);
      if (pick < 93) return sample_type'($urandom_range(1) ? mag : -mag);
      if (pick < 97) return SAMPLE_MAX;
      return SAMPLE_MIN;
   endfunction

   function automatic req_payload_type random_beat(bit restart);
      req_payload_type beat;
      beat.lower_sample  = random_sample();
      beat.centre_sample = random_sample();
      beat.upper_sample  = random_sample();
      beat.frame_start   = restart;
      return beat;
   endfunction

   // 5x5 frame: full-scale minimum and maximum, ties across layers and rows
   function automatic req_payload_type directed_beat(int r, int c);
      req_payload_type beat;
      beat             = '0;
      beat.frame_start = (r == 0 && c == 0);
      if (r == 1 && c == 1) beat.centre_sample = SAMPLE_MIN;
      if (r == 1 && c == 3) beat.centre_sample = SAMPLE_MAX;
      if (r == 0 && c == 4) beat.lower_sample  = SAMPLE_MAX;
      if (r == 4 && c == 0) beat.upper_sample  = SAMPLE_MIN;
      if (r == 3 && c == 2) begin
         beat.centre_sample = 16'sd100;
         beat.upper_sample  = 16'sd100;
      end
      if (r == 2 && c == 3) beat.lower_sample = 16'sd100;
      return beat;
   endfunction

   task automatic send_sample(input req_payload_type beat);
      while ($urandom_range(99) < req_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= beat;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int value);
      csr_chan.valid   <= 1'b1;
      csr_chan.payload <= '{index: idx, data: CSR_DATA_W'(value)};
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
   endtask

   task automatic program_regs(input int thr, input int w, input int h, input int b);
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      write_reg(CSR_BORDER, b);
      csr_chan.valid <= 1'b0;
   endtask

   // Hold off until every predicted peak is out, plus the pipeline depth
   task automatic wait_for_drain();
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input int thr, input int w, input int h, input int b,
                            input int count, input bit new_frame,
                            input int restart_pct, input bit long_hold);
      req_payload_type beat;
      wait_for_drain();
      program_regs(thr, w, h, b);
      if (long_hold) hold_requests++;
      for (int i = 0; i < count; i++) begin
         beat = random_beat((new_frame && i == 0) || ($urandom_range(99) < restart_pct));
         send_sample(beat);
      end
      req_chan.valid <= 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      csr_chan.valid   = 1'b0;
      csr_chan.payload = '0;
      req_gap_pct      = 6;
      rsp_stall_pct    = 78;
      hold_requests    = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      program_regs(0, 5, 5, 1);
      for (int r = 0; r < 5; r++) begin
         for (int c = 0; c < 5; c++) send_sample(directed_beat(r, c));
      end
      req_chan.valid <= 1'b0;

      // thr, width, height, border, beats, fresh frame, restart %, long hold
      run_phase(3, 8, 6, 1, 200, 1'b1, 1, 1'b0);
      run_phase(0, 0, 1, 0, 60, 1'b1, 0, 1'b0);
      run_phase(32767, 12, 10, 2, 150, 1'b1, 1, 1'b0);

      wait_for_drain();
      req_gap_pct   = 78;
      rsp_stall_pct = 6;
      run_phase(20, 10, 9, 64, 100, 1'b1, 0, 1'b0);
      run_phase(5, 16, 12, 3, 250, 1'b1, 2, 1'b0);
      // shrink width and height inside the running frame
      run_phase(2, 9, 7, 1, 200, 1'b0, 1, 1'b0);

      wait_for_drain();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      run_phase(1, 7, 5, 1, 220, 1'b1, 1, 1'b1);
      run_phase(0, 5000, 8191, 1, WIDE_BEATS, 1'b1, 0, 1'b0);

      wait_for_drain();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
